FILE: rtl/sha_pkg.sv
`timescale 1ns / 1ps

package sha_pkg;

  localparam int SCHED_DEPTH = 16;
  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0] waddr_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  // Fill count at which the 0x80 byte leaves no room for the length field.
  localparam logic [5:0] LEN_FIELD_START = 6'd56;

  // Control from the stream front end to the compression core.
  typedef struct packed {
    logic   start;
    logic   we;
    waddr_t waddr;
    word_t  wdata;
    logic   reinit;
    logic [2:0] sel;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t v;
    case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t v;
    case (i)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps

// Streaming SHA-256 hasher.
// Input channel (in_valid/in_ready): one beat per command. cmd 0 appends
// data_byte to the message; cmd 1 pads the message, appends its bit length
// and starts the digest.
// Output channel (out_valid/out_ready): a finish produces eight beats of
// digest_word, word_index 0 (most significant) through 7, with last on 7.
// Data beats are accepted back to back, except that the byte that fills a
// 64-byte block starts the compression, which runs one round per cycle over
// the schedule memory, and in_ready is low until it is done.
// A finish writes the padding words to the schedule memory and runs the
// compression, both twice when the length field no longer fits in the last
// block, and then gives the eight output beats. While the receiver stalls,
// the current digest word holds and no new input is accepted. After the
// eighth beat the hash state returns to the initial values. Reset loads
// the initial values and clears the byte count; buffered bytes are simply
// overwritten later.
module sha256_stream_hasher_top
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last
);

  typedef enum logic [1:0] {S_IDLE, S_PAD, S_COMP, S_OUT} state_t;

  state_t      state;
  logic [5:0]  fill;
  logic [60:0] msg_len;
  logic [23:0] acc;
  logic        fin, extra, pass2;
  waddr_t      wptr, pad_idx;
  word_t       pad_word;
  logic [2:0]  oidx;

  core_ctl_t ctl;
  core_sts_t sts;
  word_t     hash_word;

  sha_core u_core (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts), .hash_word(hash_word)
  );

  logic in_acc, out_acc, data_acc, fin_acc, len_pass;
  word_t pad_data, pad_word_next;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign data_acc = in_acc && !cmd;
  assign fin_acc  = in_acc && cmd;
  assign out_valid = (state == S_OUT);
  assign out_acc  = out_valid && out_ready;
  assign len_pass = !extra || pass2;

  always_comb begin
    case (fill[1:0])
      2'd0:    pad_word_next = {PAD_BYTE, 24'h0};
      2'd1:    pad_word_next = {acc[7:0], PAD_BYTE, 16'h0};
      2'd2:    pad_word_next = {acc[15:0], PAD_BYTE, 8'h0};
      default: pad_word_next = {acc[23:0], PAD_BYTE};
    endcase
  end

  always_comb begin
    if (!pass2 && wptr == pad_idx) begin
      pad_data = pad_word;
    end else if (len_pass && wptr == 4'd14) begin
      pad_data = msg_len[60:29];
    end else if (len_pass && wptr == 4'd15) begin
      pad_data = {msg_len[28:0], 3'b000};
    end else begin
      pad_data = '0;
    end
  end

  always_comb begin
    ctl.we     = (data_acc && fill[1:0] == 2'd3) || (state == S_PAD);
    ctl.waddr  = (state == S_PAD) ? wptr : fill[5:2];
    ctl.wdata  = (state == S_PAD) ? pad_data : {acc, data_byte};
    ctl.start  = (data_acc && fill == 6'd63) || (state == S_PAD && wptr == 4'd15);
    ctl.reinit = out_acc && oidx == 3'd7;
    ctl.sel    = oidx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      msg_len <= '0;
      fin     <= 1'b0;
      extra   <= 1'b0;
      pass2   <= 1'b0;
      wptr    <= '0;
      oidx    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (data_acc) begin
            acc     <= {acc[15:0], data_byte};
            fill    <= fill + 6'd1;
            msg_len <= msg_len + 61'd1;
            if (fill == 6'd63) begin
              fin   <= 1'b0;
              state <= S_COMP;
            end
          end else if (fin_acc) begin
            pad_word <= pad_word_next;
            pad_idx  <= fill[5:2];
            wptr     <= fill[5:2];
            extra    <= (fill >= LEN_FIELD_START);
            pass2    <= 1'b0;
            fin      <= 1'b1;
            state    <= S_PAD;
          end
        end
        S_PAD: begin
          if (wptr == 4'd15) begin
            state <= S_COMP;
          end else begin
            wptr <= wptr + 4'd1;
          end
        end
        S_COMP: begin
          if (sts.done) begin
            if (!fin) begin
              state <= S_IDLE;
            end else if (extra && !pass2) begin
              // The length did not fit: a second block of zeros carries it.
              pass2 <= 1'b1;
              wptr  <= '0;
              state <= S_PAD;
            end else begin
              oidx  <= '0;
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (oidx == 3'd7) begin
              fill    <= '0;
              msg_len <= '0;
              state   <= S_IDLE;
            end else begin
              oidx <= oidx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign digest_word = hash_word;
  assign word_index  = oidx;
  assign last        = (oidx == 3'd7);

`ifndef SYNTHESIS
  a_accept_core_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> !sts.busy)
    else $error("input beat accepted while compression runs");
  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last) |=> (in_ready && fill == 6'd0))
    else $error("block not ready for a new message after the last digest beat");
  a_out_core_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !sts.busy)
    else $error("digest shown while compression runs");
`endif

endmodule

FILE: rtl/sha_ram.sv
`timescale 1ns / 1ps

module sha_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/sha_core.sv
`timescale 1ns / 1ps

module sha_core
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  core_ctl_t ctl,
  output core_sts_t sts,
  output word_t     hash_word
);

  localparam logic [6:0] LAST_CNT = 7'd66;

  word_t hash [8];
  word_t va, vb, vc, vd, ve, vf, vg, vh;
  logic       run;
  logic [6:0] cnt;
  word_t      w_reg;
  logic [5:0] ridx;

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  // Two copies of the schedule window give four read ports per cycle.
  logic   ram_we;
  waddr_t ram_waddr;
  word_t  ram_wdata;
  waddr_t ra0, rb0, ra1, rb1;
  word_t  d_a0, d_b0, d_a1, d_b1;

  sha_ram #(.DEPTH(SCHED_DEPTH), .WIDTH(WORD_W)) u_ram0 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr_a(ra0), .raddr_b(rb0), .rdata_a(d_a0), .rdata_b(d_b0)
  );

  sha_ram #(.DEPTH(SCHED_DEPTH), .WIDTH(WORD_W)) u_ram1 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr_a(ra1), .raddr_b(rb1), .rdata_a(d_a1), .rdata_b(d_b1)
  );

  // Read issue for schedule word cnt: W[i-16] (or W[i]), W[i-15], W[i-7], W[i-2].
  logic [3:0] iidx;
  assign iidx = cnt[3:0];
  assign ra0  = iidx;
  assign rb0  = iidx + 4'd1;
  assign ra1  = iidx - 4'd7;
  assign rb1  = iidx - 4'd2;

  logic       comp_v, round_v;
  logic [5:0] cidx;
  word_t      s0, s1, w_calc;

  assign comp_v = run && (cnt >= 7'd1) && (cnt <= 7'd64);
  assign round_v = run && (cnt >= 7'd2) && (cnt <= 7'd65);
  assign cidx = cnt[5:0] - 6'd1;

  always_comb begin
    s0 = rotr(d_b0, 7) ^ rotr(d_b0, 18) ^ (d_b0 >> 3);
    s1 = rotr(d_b1, 17) ^ rotr(d_b1, 19) ^ (d_b1 >> 10);
    if (cidx[5:4] == 2'd0) begin
      w_calc = d_a0;
    end else begin
      w_calc = d_a0 + s0 + d_a1 + s1;
    end
  end

  always_comb begin
    if (run) begin
      ram_we    = comp_v && (cidx[5:4] != 2'd0);
      ram_waddr = cidx[3:0];
      ram_wdata = w_calc;
    end else begin
      ram_we    = ctl.we;
      ram_waddr = ctl.waddr;
      ram_wdata = ctl.wdata;
    end
  end

  word_t big0, big1, ch, maj, t1, t2;

  always_comb begin
    big1 = rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25);
    ch   = (ve & vf) ^ (~ve & vg);
    t1   = vh + big1 + ch + round_k(ridx) + w_reg;
    big0 = rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22);
    maj  = (va & vb) ^ (va & vc) ^ (vb & vc);
    t2   = big0 + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      for (int j = 0; j < 8; j++) begin
        hash[j] <= init_hash(3'(j));
      end
    end else begin
      if (ctl.reinit) begin
        for (int j = 0; j < 8; j++) begin
          hash[j] <= init_hash(3'(j));
        end
      end
      if (ctl.start && !run) begin
        run <= 1'b1;
        cnt <= '0;
        va <= hash[0]; vb <= hash[1]; vc <= hash[2]; vd <= hash[3];
        ve <= hash[4]; vf <= hash[5]; vg <= hash[6]; vh <= hash[7];
      end else if (run) begin
        cnt <= cnt + 7'd1;
        if (comp_v) begin
          w_reg <= w_calc;
          ridx  <= cidx;
        end
        if (round_v) begin
          vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
          vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
        end
        if (cnt == LAST_CNT) begin
          run <= 1'b0;
          hash[0] <= hash[0] + va; hash[1] <= hash[1] + vb;
          hash[2] <= hash[2] + vc; hash[3] <= hash[3] + vd;
          hash[4] <= hash[4] + ve; hash[5] <= hash[5] + vf;
          hash[6] <= hash[6] + vg; hash[7] <= hash[7] + vh;
        end
      end
    end
  end

  assign sts.busy  = run;
  assign sts.done  = run && (cnt == LAST_CNT);
  assign hash_word = hash[ctl.sel];

`ifndef SYNTHESIS
  a_no_host_write_in_run: assert property (@(posedge clk) disable iff (rst)
    run |-> !ctl.we)
    else $error("host write to schedule memory during compression");
  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    sts.done |=> !run)
    else $error("compression did not stop after done");
  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !run)
    else $error("compression started while busy");
`endif

endmodule
